FILE: rtl/core/ehs_pkg.sv
// ----------------------------------------------------------------------------
// ehs_pkg
// shared constants, codes and types of the exposure histogram block
// ----------------------------------------------------------------------------
package ehs_pkg;

    localparam int PIX_W      = 8;
    localparam int PIXELS     = 4;
    localparam int PIX_IDX_W  = 2;
    localparam int HIT_W      = 3;
    localparam int GROUP_W    = 32;
    localparam int COUNT_W    = 32;
    localparam int BINS       = 256;
    localparam int BIN_W      = 8;
    localparam int OP_W       = 2;
    localparam int CLS_W      = 2;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_PTR_W = 2;
    localparam int RESQ_CNT_W = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index sits in the top bit of paddr
    localparam logic REG_SATURATION_LEVEL = 1'b0;

    localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [CLS_W-1:0] CLS_NONE    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_FULL    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_PARTIAL = 2'd2;

    localparam logic [PIX_W-1:0]   LEVEL_RST    = 8'hff;
    localparam logic [PIX_W-1:0]   PART_LOW_RST = 8'hff;
    localparam logic [PIX_W-1:0]   PART_HIGH_RST = 8'h00;
    localparam logic [COUNT_W-1:0] GROUP_STEP   = COUNT_W'(PIXELS);

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [GROUP_W-1:0] pixels;
        logic [BIN_W-1:0]   bin;
        logic [CLS_W-1:0]   cls;
        logic [PIX_W-1:0]   gmin;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0] saturated_total;
        logic [COUNT_W-1:0] near_saturated_total;
        logic [PIX_W-1:0]   partial_min;
        logic [PIX_W-1:0]   partial_max;
        logic [COUNT_W-1:0] pixel_total;
        logic [COUNT_W-1:0] bin_value;
    } result_t;

endpackage

FILE: rtl/core/ehs_ram.sv
// ----------------------------------------------------------------------------
// ehs_ram
// generic ram, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module ehs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ehs_front.sv
// ----------------------------------------------------------------------------
// ehs_front
// accepts requests, classifies pixel groups against the saturation level and
// holds them in a short command queue for the back end
// ----------------------------------------------------------------------------
module ehs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ehs_pkg::PIX_W-1:0]     level,
    input  logic                          push,
    output logic                          full,
    input  logic [ehs_pkg::OP_W-1:0]      operation,
    input  logic [ehs_pkg::GROUP_W-1:0]   pixel_group,
    input  logic [ehs_pkg::BIN_W-1:0]     bin_index,
    input  logic                          cmd_pop,
    output logic                          cmd_empty,
    output ehs_pkg::cmd_t                 cmd
);

    logic [ehs_pkg::PIX_W-1:0]      grp_min;
    logic [ehs_pkg::HIT_W-1:0]      hit_cnt;
    ehs_pkg::cmd_t                  entry;

    ehs_pkg::cmd_t                  q_mem_reg [ehs_pkg::CMDQ_DEPTH];
    logic [ehs_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ehs_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ehs_pkg::CMDQ_CNT_W-1:0] count_reg, count_next;
    logic                           push_ok;
    logic                           pop_ok;

    // group minimum and count of saturated pixels
    always_comb
    begin
        grp_min = ehs_pkg::PART_LOW_RST;
        hit_cnt = '0;
        for (int k = 0; k < ehs_pkg::PIXELS; k++)
        begin
            if (pixel_group[k*ehs_pkg::PIX_W +: ehs_pkg::PIX_W] < grp_min)
            begin
                grp_min = pixel_group[k*ehs_pkg::PIX_W +: ehs_pkg::PIX_W];
            end
            if (pixel_group[k*ehs_pkg::PIX_W +: ehs_pkg::PIX_W] >= level)
            begin
                hit_cnt = hit_cnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        entry.op     = operation;
        entry.pixels = pixel_group;
        entry.bin    = bin_index;
        entry.gmin   = grp_min;
        if (hit_cnt == ehs_pkg::HIT_W'(ehs_pkg::PIXELS))
        begin
            entry.cls = ehs_pkg::CLS_FULL;
        end
        else if (hit_cnt != '0)
        begin
            entry.cls = ehs_pkg::CLS_PARTIAL;
        end
        else
        begin
            entry.cls = ehs_pkg::CLS_NONE;
        end
    end

    assign full      = (count_reg == ehs_pkg::CMDQ_CNT_W'(ehs_pkg::CMDQ_DEPTH));
    assign cmd_empty = (count_reg == '0);
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && !cmd_empty;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

    a_cmdq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ehs_pkg::CMDQ_CNT_W'(ehs_pkg::CMDQ_DEPTH))
        else $error("command queue count out of range");

endmodule

FILE: rtl/core/ehs_back.sv
// ----------------------------------------------------------------------------
// ehs_back
// executes commands: one histogram read-modify-write per accumulated pixel
// via a two-stage pipeline with write forwarding, plus the running statistics
// ----------------------------------------------------------------------------
module ehs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ehs_pkg::cmd_t                   cmd,
    input  logic                            cmd_empty,
    output logic                            cmd_pop,
    input  logic [ehs_pkg::RESQ_CNT_W-1:0]  res_count,
    output logic                            res_push,
    output ehs_pkg::result_t                res
);

    ehs_pkg::cmd_t                  cur_reg;
    logic                           cur_valid_reg;
    logic [ehs_pkg::PIX_IDX_W-1:0]  pix_idx_reg;

    logic                           slot_last;
    logic                           credit_ok;
    logic                           issue;
    logic                           issue_last;
    logic [ehs_pkg::BIN_W-1:0]      rd_addr;

    logic                           w_valid_reg;
    logic                           w_last_reg;
    logic [ehs_pkg::OP_W-1:0]       w_op_reg;
    logic [ehs_pkg::BIN_W-1:0]      w_addr_reg;
    logic [ehs_pkg::CLS_W-1:0]      w_cls_reg;
    logic [ehs_pkg::PIX_W-1:0]      w_gmin_reg;

    logic                           fwd_valid_reg;
    logic [ehs_pkg::BIN_W-1:0]      fwd_addr_reg;
    logic [ehs_pkg::COUNT_W-1:0]    fwd_data_reg;

    logic [ehs_pkg::BINS-1:0]       hist_valid_reg;
    logic [ehs_pkg::COUNT_W-1:0]    hist_rdata;
    logic [ehs_pkg::COUNT_W-1:0]    bin_base;
    logic [ehs_pkg::COUNT_W-1:0]    hist_wdata;
    logic                           hist_we;
    logic                           w_clear;

    logic [ehs_pkg::COUNT_W-1:0]    sat_reg, sat_next;
    logic [ehs_pkg::COUNT_W-1:0]    near_reg, near_next;
    logic [ehs_pkg::PIX_W-1:0]      low_reg, low_next;
    logic [ehs_pkg::PIX_W-1:0]      high_reg, high_next;
    logic [ehs_pkg::COUNT_W-1:0]    total_reg, total_next;

    // ---------------------------------------------------------------- issue

    assign slot_last = (cur_reg.op != ehs_pkg::OP_ACC)
                    || (pix_idx_reg == ehs_pkg::PIX_IDX_W'(ehs_pkg::PIXELS - 1));

    // a result slot may only issue if the result queue has room for it
    assign credit_ok = ((ehs_pkg::RESQ_CNT_W + 1)'(res_count)
                      + (ehs_pkg::RESQ_CNT_W + 1)'(w_valid_reg && w_last_reg))
                      < (ehs_pkg::RESQ_CNT_W + 1)'(ehs_pkg::RESQ_DEPTH);

    assign issue      = cur_valid_reg && (!slot_last || credit_ok);
    assign issue_last = issue && slot_last;
    assign cmd_pop    = !cmd_empty && (!cur_valid_reg || issue_last);

    assign rd_addr = (cur_reg.op == ehs_pkg::OP_ACC)
                   ? cur_reg.pixels[pix_idx_reg*ehs_pkg::PIX_W +: ehs_pkg::PIX_W]
                   : cur_reg.bin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pix_idx_reg   <= '0;
        end
        else if (cmd_pop)
        begin
            cur_valid_reg <= 1'b1;
            pix_idx_reg   <= '0;
        end
        else if (issue_last)
        begin
            cur_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            pix_idx_reg <= pix_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
    end

    // ---------------------------------------------------------- write stage

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
        end
        else
        begin
            w_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            w_last_reg <= slot_last;
            w_op_reg   <= cur_reg.op;
            w_addr_reg <= rd_addr;
            w_cls_reg  <= cur_reg.cls;
            w_gmin_reg <= cur_reg.gmin;
        end
    end

    ehs_ram #(
        .WIDTH (ehs_pkg::COUNT_W),
        .DEPTH (ehs_pkg::BINS)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (w_addr_reg),
        .wdata (hist_wdata),
        .raddr (rd_addr),
        .rdata (hist_rdata)
    );

    // the ram read misses a write made in the cycle before, so forward it
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == w_addr_reg))
        begin
            bin_base = fwd_data_reg;
        end
        else if (hist_valid_reg[w_addr_reg])
        begin
            bin_base = hist_rdata;
        end
        else
        begin
            bin_base = '0;
        end
    end

    assign hist_we    = w_valid_reg && (w_op_reg == ehs_pkg::OP_ACC);
    assign hist_wdata = bin_base + 1'b1;
    assign w_clear    = w_valid_reg && (w_op_reg == ehs_pkg::OP_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg  <= 1'b0;
            hist_valid_reg <= '0;
        end
        else
        begin
            fwd_valid_reg <= hist_we;
            if (w_clear)
            begin
                hist_valid_reg <= '0;
            end
            else if (hist_we)
            begin
                hist_valid_reg[w_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            fwd_addr_reg <= w_addr_reg;
            fwd_data_reg <= hist_wdata;
        end
    end

    // ----------------------------------------------------------- statistics

    always_comb
    begin
        sat_next   = sat_reg;
        near_next  = near_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        total_next = total_reg;
        if (w_valid_reg && w_last_reg)
        begin
            case (w_op_reg)
                ehs_pkg::OP_ACC:
                begin
                    total_next = total_reg + ehs_pkg::GROUP_STEP;
                    if (w_cls_reg == ehs_pkg::CLS_FULL)
                    begin
                        sat_next = sat_reg + ehs_pkg::GROUP_STEP;
                    end
                    else if (w_cls_reg == ehs_pkg::CLS_PARTIAL)
                    begin
                        near_next = near_reg + ehs_pkg::GROUP_STEP;
                        if (w_gmin_reg < low_reg)
                        begin
                            low_next = w_gmin_reg;
                        end
                        if (w_gmin_reg > high_reg)
                        begin
                            high_next = w_gmin_reg;
                        end
                    end
                end
                ehs_pkg::OP_CLEAR:
                begin
                    sat_next   = '0;
                    near_next  = '0;
                    low_next   = ehs_pkg::PART_LOW_RST;
                    high_next  = ehs_pkg::PART_HIGH_RST;
                    total_next = '0;
                end
                default:
                begin
                    total_next = total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= '0;
            near_reg  <= '0;
            low_reg   <= ehs_pkg::PART_LOW_RST;
            high_reg  <= ehs_pkg::PART_HIGH_RST;
            total_reg <= '0;
        end
        else
        begin
            sat_reg   <= sat_next;
            near_reg  <= near_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            total_reg <= total_next;
        end
    end

    assign res_push                 = w_valid_reg && w_last_reg;
    assign res.saturated_total      = sat_next;
    assign res.near_saturated_total = near_next;
    assign res.partial_min          = low_next;
    assign res.partial_max          = high_next;
    assign res.pixel_total          = total_next;
    assign res.bin_value            = (w_op_reg == ehs_pkg::OP_READ) ? bin_base : '0;

    a_res_credit: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_count < ehs_pkg::RESQ_CNT_W'(ehs_pkg::RESQ_DEPTH)))
        else $error("result pushed without queue space");

    a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && (cur_reg.op != ehs_pkg::OP_ACC)) |-> (pix_idx_reg == '0))
        else $error("pixel index moved on a single-slot request");

    a_clear_bins: assert property (@(posedge clk) disable iff (!rst_n)
        w_clear |=> (hist_valid_reg == '0))
        else $error("histogram bins not cleared");

endmodule

FILE: rtl/core/ehs_resq.sv
// ----------------------------------------------------------------------------
// ehs_resq
// result queue in front of the result ports, oldest result on the head
// ----------------------------------------------------------------------------
module ehs_resq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  ehs_pkg::result_t                res,
    input  logic                            pop,
    output logic                            empty,
    output logic [ehs_pkg::RESQ_CNT_W-1:0]  count,
    output ehs_pkg::result_t                head
);

    ehs_pkg::result_t               q_mem_reg [ehs_pkg::RESQ_DEPTH];
    logic [ehs_pkg::RESQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ehs_pkg::RESQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ehs_pkg::RESQ_CNT_W-1:0] count_reg, count_next;
    logic                           pop_ok;

    assign empty  = (count_reg == '0);
    assign count  = count_reg;
    assign head   = q_mem_reg[rd_ptr_reg];
    assign pop_ok = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

FILE: rtl/core/exposure_histogram_specular_stats.sv
// ----------------------------------------------------------------------------
// exposure_histogram_specular_stats
// auto-exposure statistics: 256-bin pixel histogram, saturation counts and
// the range of group minimums among partly saturated groups
// ----------------------------------------------------------------------------
// an accumulate request makes one histogram update per pixel through the ram
// write port, so the next request is taken only as its last pixel issues;
// other requests 1 per cycle while the result queue has room
// reset: rst_n clears all statistics and queues at once, bin valid flags make
// every histogram bin read as zero, no clearing pass; saturation level 255
// ----------------------------------------------------------------------------
module exposure_histogram_specular_stats (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ehs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ehs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ehs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,

    input  logic                               push,
    output logic                               full,
    input  logic [ehs_pkg::OP_W-1:0]           operation,
    input  logic [ehs_pkg::GROUP_W-1:0]        pixel_group,
    input  logic [ehs_pkg::BIN_W-1:0]          bin_index,

    output logic                               empty,
    input  logic                               pop,
    output logic [ehs_pkg::COUNT_W-1:0]        saturated_total,
    output logic [ehs_pkg::COUNT_W-1:0]        near_saturated_total,
    output logic [ehs_pkg::PIX_W-1:0]          partial_min,
    output logic [ehs_pkg::PIX_W-1:0]          partial_max,
    output logic [ehs_pkg::COUNT_W-1:0]        pixel_total,
    output logic [ehs_pkg::COUNT_W-1:0]        bin_value
);

    logic [ehs_pkg::PIX_W-1:0]          level_reg;
    logic                               cfg_write;
    logic                               level_sel;

    ehs_pkg::cmd_t                      cmd;
    logic                               cmd_empty;
    logic                               cmd_pop;
    ehs_pkg::result_t                   res;
    logic                               res_push;
    logic [ehs_pkg::RESQ_CNT_W-1:0]     res_count;
    ehs_pkg::result_t                   head;

    // configuration port
    assign pready    = 1'b1;
    assign level_sel = (paddr[ehs_pkg::APB_ADDR_W-1] == ehs_pkg::REG_SATURATION_LEVEL);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = level_sel ? ehs_pkg::APB_DATA_W'(level_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= ehs_pkg::LEVEL_RST;
        end
        else if (cfg_write && level_sel)
        begin
            level_reg <= pwdata[ehs_pkg::PIX_W-1:0];
        end
    end

    ehs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .level       (level_reg),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .pixel_group (pixel_group),
        .bin_index   (bin_index),
        .cmd_pop     (cmd_pop),
        .cmd_empty   (cmd_empty),
        .cmd         (cmd)
    );

    ehs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res       (res)
    );

    ehs_resq u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .res   (res),
        .pop   (pop),
        .empty (empty),
        .count (res_count),
        .head  (head)
    );

    assign saturated_total      = head.saturated_total;
    assign near_saturated_total = head.near_saturated_total;
    assign partial_min          = head.partial_min;
    assign partial_max          = head.partial_max;
    assign pixel_total          = head.pixel_total;
    assign bin_value            = head.bin_value;

endmodule
